// ----- rtl/ltsm_pkg.sv -----
// Shared types and constants for the loop time statistics monitor.
package ltsm_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned JIT_W    = 40;
    localparam int unsigned FRAC_W   = 8;
    localparam int unsigned COEF_W   = 16;
    localparam int unsigned OVH_W    = 8;

    localparam logic [COEF_W-1:0] COEF_NEW     = 16'd13107;
    localparam logic [OVH_W-1:0]  OVERHEAD_RST = 8'd2;
    localparam logic [TIME_W-1:0] TIME_ONES    = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_ENTER = 2'd0,
        REQ_EXIT  = 2'd1,
        REQ_EPOCH = 2'd2
    } t_req_kind;

    typedef struct packed {
        logic [TIME_W-1:0] last_loop_us;
        logic [TIME_W-1:0] min_loop_us;
        logic [TIME_W-1:0] max_loop_us;
        logic [TIME_W-1:0] sum_loop_us;
        logic [TIME_W-1:0] loops_seen;
        logic [JIT_W-1:0]  jitter_q8;
    } t_stats;

endpackage

// ----- rtl/ltsm_req_if.sv -----
// Handshake channels for event items and statistics items.
interface ltsm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] timestamp_us;

    modport source (output valid, output req_type, output timestamp_us, input ready);
    modport sink   (input valid, input req_type, input timestamp_us, output ready);
endinterface

interface ltsm_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] last_loop_us;
    logic [31:0] min_loop_us;
    logic [31:0] max_loop_us;
    logic [31:0] sum_loop_us;
    logic [31:0] loops_seen;
    logic [39:0] jitter_q8;

    modport source (output valid, output last_loop_us, output min_loop_us,
                    output max_loop_us, output sum_loop_us, output loops_seen,
                    output jitter_q8, input ready);
    modport sink   (input valid, input last_loop_us, input min_loop_us,
                    input max_loop_us, input sum_loop_us, input loops_seen,
                    input jitter_q8, output ready);
endinterface

// ----- rtl/ltsm_stats_core.sv -----
// Statistics state registers and their combinational update for one event.
module ltsm_stats_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [1:0]                  i_kind,
    input  logic [ltsm_pkg::TIME_W-1:0] i_ts,
    input  logic [ltsm_pkg::OVH_W-1:0]  i_overhead,
    output ltsm_pkg::t_stats            o_next
);
    import ltsm_pkg::*;

    localparam int unsigned DIFF_W = JIT_W + 1;
    localparam int unsigned PROD_W = DIFF_W + COEF_W + 1;
    localparam int unsigned ACC_W  = PROD_W + 1;

    logic [TIME_W-1:0] r_start;
    t_stats            r_st;
    logic [TIME_W-1:0] n_start;
    t_stats            n_st;

    logic [TIME_W-1:0]        elapsed_raw;
    logic [TIME_W-1:0]        elapsed;
    logic [TIME_W-1:0]        delta;
    logic signed [DIFF_W-1:0] jit_diff;
    logic signed [PROD_W-1:0] jit_prod;
    logic signed [ACC_W-1:0]  jit_acc;
    logic [JIT_W-1:0]         jit_new;

    always_comb begin
        elapsed_raw = i_ts - r_start;
        if (elapsed_raw > TIME_W'(i_overhead)) begin
            elapsed = elapsed_raw - TIME_W'(i_overhead);
        end else begin
            elapsed = elapsed_raw;
        end
        delta = (elapsed > r_st.last_loop_us) ? (elapsed - r_st.last_loop_us)
                                              : (r_st.last_loop_us - elapsed);
        // 0.2*d + 0.8*j == j + 0.2*(d - j), one constant multiply
        jit_diff = $signed({1'b0, delta, {FRAC_W{1'b0}}}) - $signed({1'b0, r_st.jitter_q8});
        jit_prod = $signed({1'b0, COEF_NEW}) * jit_diff;
        jit_acc  = $signed({1'b0, r_st.jitter_q8, {COEF_W{1'b0}}}) + ACC_W'(jit_prod);
        jit_new  = jit_acc[COEF_W +: JIT_W];
    end

    always_comb begin
        n_start = r_start;
        n_st    = r_st;
        case (t_req_kind'(i_kind))
            REQ_ENTER: begin
                n_start = i_ts;
            end
            REQ_EXIT: begin
                if (r_st.loops_seen != '0) begin
                    n_st.jitter_q8 = jit_new;
                end
                n_st.last_loop_us = elapsed;
                n_st.sum_loop_us  = r_st.sum_loop_us + elapsed;
                n_st.loops_seen   = r_st.loops_seen + TIME_W'(1);
                if (elapsed < r_st.min_loop_us) begin
                    n_st.min_loop_us = elapsed;
                end
                if (elapsed > r_st.max_loop_us) begin
                    n_st.max_loop_us = elapsed;
                end
            end
            REQ_EPOCH: begin
                n_st.sum_loop_us = '0;
                n_st.loops_seen  = '0;
                n_st.min_loop_us = TIME_ONES;
                n_st.max_loop_us = '0;
            end
            default: begin
            end
        endcase
    end

    assign o_next = n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start           <= '0;
            r_st.last_loop_us <= '0;
            r_st.min_loop_us  <= TIME_ONES;
            r_st.max_loop_us  <= '0;
            r_st.sum_loop_us  <= '0;
            r_st.loops_seen   <= '0;
            r_st.jitter_q8    <= '0;
        end else if (i_en) begin
            r_start <= n_start;
            r_st    <= n_st;
        end
    end

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.loops_seen != '0) |-> (r_st.min_loop_us <= r_st.max_loop_us))
        else $error("min above max with loops recorded");

    a_epoch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_kind == REQ_EPOCH) |=>
        (r_st.loops_seen == '0 && r_st.min_loop_us == TIME_ONES && r_st.max_loop_us == '0))
        else $error("epoch reset left statistics");

    a_exit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_kind == REQ_EXIT) |=>
        (r_st.loops_seen == $past(r_st.loops_seen) + TIME_W'(1)))
        else $error("loop count not advanced on exit");

endmodule

// ----- rtl/ltsm_out_reg.sv -----
// Result register that holds one statistics item until the receiver takes it.
module ltsm_out_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  ltsm_pkg::t_stats i_data,
    output logic            o_can_load,
    ltsm_res_if.source      o_res
);
    import ltsm_pkg::*;

    logic   r_valid;
    t_stats r_data;

    assign o_can_load = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_data <= i_data;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.last_loop_us = r_data.last_loop_us;
    assign o_res.min_loop_us  = r_data.min_loop_us;
    assign o_res.max_loop_us  = r_data.max_loop_us;
    assign o_res.sum_loop_us  = r_data.sum_loop_us;
    assign o_res.loops_seen   = r_data.loops_seen;
    assign o_res.jitter_q8    = r_data.jitter_q8;

endmodule

// ----- rtl/loop_time_stats_monitor.sv -----
// Top level of the loop time statistics monitor.
// Usage:
//   i_req carries event items: req_type (0 loop enter, 1 loop exit, 2 epoch
//   reset) and a free-running 32-bit microsecond timestamp_us.
//   o_res carries one statistics item per event: last, min, max, total,
//   loop count and jitter (Q32.8), all as they stand after that event.
//   i_cfg_wr_en / i_cfg_wr_data write the 8-bit probe overhead; write it
//   only while no items are in flight.
// Timing:
//   An item is registered in the input register when it is accepted; its
//   statistics are computed from that register and land in the result
//   register, which raises o_res.valid. One item per cycle is sustained
//   while o_res is not stalled; the state update (subtract, compare, one
//   constant multiply) is combinational.
// Reset and stall:
//   Synchronous reset empties both registers, sets overhead to 2, min to all
//   ones and every other statistic and the start time to zero. When o_res is
//   stalled the result register holds, the input register holds its item and
//   i_req.ready drops once both are full.
module loop_time_stats_monitor (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [ltsm_pkg::OVH_W-1:0] i_cfg_wr_data,
    ltsm_req_if.sink                   i_req,
    ltsm_res_if.source                 o_res
);
    import ltsm_pkg::*;

    logic              r_in_valid;
    logic [1:0]        r_in_kind;
    logic [TIME_W-1:0] r_in_ts;
    logic [OVH_W-1:0]  r_overhead;

    logic   advance;
    logic   step;
    t_stats stats_next;

    assign step         = r_in_valid && advance;
    assign i_req.ready  = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_overhead <= OVERHEAD_RST;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (i_cfg_wr_en) begin
                r_overhead <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_kind <= i_req.req_type;
            r_in_ts   <= i_req.timestamp_us;
        end
    end

    ltsm_stats_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (step),
        .i_kind     (r_in_kind),
        .i_ts       (r_in_ts),
        .i_overhead (r_overhead),
        .o_next     (stats_next)
    );

    ltsm_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (r_in_valid),
        .i_data     (stats_next),
        .o_can_load (advance),
        .o_res      (o_res)
    );

endmodule
